// ----- hdl/sbp_pkg.sv -----
package sbp_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned DescBits = 7;
  localparam int unsigned FillW    = 3;
  localparam int unsigned DescCntW = 3;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StScan   = 6'b000010,
    StMag    = 6'b000100,
    StDesc   = 6'b001000,
    StFlushM = 6'b010000,
    StFlushD = 6'b100000
  } state_e;

  typedef enum logic {
    SelMag  = 1'b0,
    SelDesc = 1'b1
  } stream_e;

  typedef enum logic {
    CmdPack  = 1'b0,
    CmdFlush = 1'b1
  } cmd_e;

endpackage

// ----- hdl/significant_bit_packer.sv -----
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_ready_o cmd_i, value_i
// result    out        out_valid_o/out_ready_i stream_sel_o, out_byte_o, last_o
//
// A pack request is accepted in the idle state; the shared one-bit shifter then runs the
// leading-zero scan (which ends in a step of its own) and shifts out the magnitude bits,
// and the seven descriptor bits are shifted out after them.
// A flush request passes through the magnitude-flush and descriptor-flush states.
// Every emitted byte waits in the single output register; a stalled output holds the
// sequencer on that step. Reset clears both accumulators and the output valid flag.
module significant_bit_packer
  import sbp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        stream_sel_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic [DescBits-1:0]   desc_q, desc_d;
  logic [DescCntW-1:0]   dcnt_q, dcnt_d;

  logic [ByteBits-1:0] mag_acc_q, mag_acc_d;
  logic [FillW-1:0]    mag_fill_q, mag_fill_d;
  logic [ByteBits-1:0] desc_acc_q, desc_acc_d;
  logic [FillW-1:0]    desc_fill_q, desc_fill_d;

  logic                out_vld_q, out_vld_d;
  logic                out_sel_q, out_sel_d;
  logic [ByteBits-1:0] out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  logic                  out_free;
  logic [VALUE_BITS-1:0] raw;
  logic                  raw_neg;
  logic [ByteBits-1:0]   mag_push, desc_push;
  logic [FillW-1:0]      mag_shamt, desc_shamt;

  assign out_free   = !out_vld_q || out_ready_i;
  assign raw        = value_i[VALUE_BITS-1:0];
  assign raw_neg    = raw[VALUE_BITS-1];
  assign mag_push   = {mag_acc_q[ByteBits-2:0], mag_q[VALUE_BITS-1]};
  assign desc_push  = {desc_acc_q[ByteBits-2:0], desc_q[DescBits-1]};
  // Left-justify a partial byte: shift by eight minus the fill, modulo eight.
  assign mag_shamt  = FillW'(4'd8 - {1'b0, mag_fill_q});
  assign desc_shamt = FillW'(4'd8 - {1'b0, desc_fill_q});

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    desc_d      = desc_q;
    dcnt_d      = dcnt_q;
    mag_acc_d   = mag_acc_q;
    mag_fill_d  = mag_fill_q;
    desc_acc_d  = desc_acc_q;
    desc_fill_d = desc_fill_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_sel_d   = out_sel_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (cmd_e'(cmd_i) == CmdFlush) begin
            state_d = StFlushM;
          end else begin
            neg_d   = raw_neg;
            mag_d   = raw_neg ? (~raw + VALUE_BITS'(1)) : raw;
            cnt_d   = CntW'(VALUE_BITS);
            state_d = StScan;
          end
        end
      end
      StScan: begin
        // Strip leading zeros, keeping at least one bit.
        if (cnt_q > CntW'(1) && !mag_q[VALUE_BITS-1]) begin
          mag_d = mag_q << 1;
          cnt_d = cnt_q - CntW'(1);
        end else begin
          desc_d  = {6'(cnt_q), neg_q};
          dcnt_d  = DescCntW'(DescBits);
          state_d = StMag;
        end
      end
      StMag: begin
        if (mag_fill_q != FillW'(ByteBits - 1) || out_free) begin
          if (mag_fill_q == FillW'(ByteBits - 1)) begin
            out_vld_d  = 1'b1;
            out_sel_d  = SelMag;
            out_byte_d = mag_push;
            // No later byte of this request when fewer than eight bits remain and
            // the descriptor cannot complete a byte either.
            out_last_d = (cnt_q <= CntW'(ByteBits)) && (desc_fill_q == '0);
            mag_acc_d  = '0;
            mag_fill_d = '0;
          end else begin
            mag_acc_d  = mag_push;
            mag_fill_d = mag_fill_q + FillW'(1);
          end
          mag_d = mag_q << 1;
          cnt_d = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_d = StDesc;
          end
        end
      end
      StDesc: begin
        if (desc_fill_q != FillW'(ByteBits - 1) || out_free) begin
          if (desc_fill_q == FillW'(ByteBits - 1)) begin
            out_vld_d   = 1'b1;
            out_sel_d   = SelDesc;
            out_byte_d  = desc_push;
            out_last_d  = 1'b1;
            desc_acc_d  = '0;
            desc_fill_d = '0;
          end else begin
            desc_acc_d  = desc_push;
            desc_fill_d = desc_fill_q + FillW'(1);
          end
          desc_d = desc_q << 1;
          dcnt_d = dcnt_q - DescCntW'(1);
          if (dcnt_q == DescCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      StFlushM: begin
        if (mag_fill_q == '0) begin
          state_d = StFlushD;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_sel_d  = SelMag;
          out_byte_d = mag_acc_q << mag_shamt;
          out_last_d = (desc_fill_q == '0);
          mag_acc_d  = '0;
          mag_fill_d = '0;
          state_d    = StFlushD;
        end
      end
      StFlushD: begin
        if (desc_fill_q == '0) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_vld_d   = 1'b1;
          out_sel_d   = SelDesc;
          out_byte_d  = desc_acc_q << desc_shamt;
          out_last_d  = 1'b1;
          desc_acc_d  = '0;
          desc_fill_d = '0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mag_acc_q   <= '0;
      mag_fill_q  <= '0;
      desc_acc_q  <= '0;
      desc_fill_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      mag_acc_q   <= mag_acc_d;
      mag_fill_q  <= mag_fill_d;
      desc_acc_q  <= desc_acc_d;
      desc_fill_q <= desc_fill_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    desc_q     <= desc_d;
    dcnt_q     <= dcnt_d;
    out_sel_q  <= out_sel_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_vld_q;
  assign stream_sel_o = out_sel_q;
  assign out_byte_o   = out_byte_q;
  assign last_o       = out_last_q;

endmodule
